### src/clts_pkg.sv
`timescale 1ns / 1ps
package clts_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SPD_W = 20;
  localparam int DT_W = 17;
  localparam int POS_W = 31;
  localparam int K_W = 32;
  localparam int TIME_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_W = 152;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_LENGTH = 3'd4;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage

### src/clts_div.sv
`timescale 1ns / 1ps
module clts_div
  import clts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) rsp.done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");
  property p_no_start_busy;
    @(posedge clk) disable iff (rst) req.start |-> !busy;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy) else $error("start while busy");
  property p_cnt;
    @(posedge clk) disable iff (rst) busy && !req.start |-> cnt != 7'd0;
  endproperty
  a_cnt: assert property (p_cnt) else $error("count underrun");
endmodule

### src/clts_sqrt.sv
`timescale 1ns / 1ps
module clts_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] arg,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] x;
  logic [63:0] r;
  logic [63:0] bitv;
  logic        busy;
  logic [64:0] sum;

  assign sum = {1'b0, r} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        x    <= arg;
        r    <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if ({1'b0, x} >= sum) begin
          x <= x - sum[63:0];
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = r[31:0];

  property p_done;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done: assert property (p_done) else $error("sqrt done without busy");
  property p_onehot;
    @(posedge clk) disable iff (rst) busy |-> $onehot(bitv);
  endproperty
  a_onehot: assert property (p_onehot) else $error("sqrt bit not one-hot");
  property p_idle_after;
    @(posedge clk) disable iff (rst) done |-> !busy;
  endproperty
  a_idle_after: assert property (p_idle_after) else $error("sqrt busy after done");
endmodule

### src/curvature_limited_trapezoid_speed.sv
`timescale 1ns / 1ps
// Channel  Dir  Signals                         Content
// s_axis   in   s_axis_tvalid/tready/tdata      curvature_here; tuser = restart
// m_axis   out  m_axis_tvalid/tready/tdata      speed..time_stamp; tlast = last_point
// cfg      in   cfg_valid/ready/index/data      register writes
// An item runs from its transfer to its first point through a 64-step divide for
// the accel distance, a 64-step divide and a 32-step root for the curve limit, then a
// 32-step root for the ramp, all serial in shared units. A straight tick on the flat part runs
// only the accel divide, a tick at or past the path end none; zero accel_limit skips the first divide.
// Reset (rst, synchronous) restores register defaults and clears position, time, speed.
// A second point (final) follows one transfer after the first; a stalled m_axis holds.
// s_axis_tready is high only while the sequencer is idle and no point waits.
module curvature_limited_trapezoid_speed
  import clts_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // curvature_here
  input  logic                  s_axis_tuser,  // restart
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,  // speed, turn_rate, curvature_echo,
                                               // arc_position, time_stamp, zero pad
  output logic                  m_axis_tlast,  // last_point
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [SPD_W-1:0] MIN_SPEED = SPD_W'((ONE_Q + 64'd50) / 64'd100);
  localparam logic [K_W-1:0] STRAIGHT = K_W'((ONE_Q + 64'd999999) / 64'd1000000);
  localparam logic [63:0] QCAP = (64'd1 << 40) >> FRAC_BITS;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_AD    = 11'b00000000010,
    S_ADW   = 11'b00000000100,
    S_CK    = 11'b00000001000,
    S_CKW   = 11'b00000010000,
    S_CS    = 11'b00000100000,
    S_CSW   = 11'b00001000000,
    S_ES    = 11'b00010000000,
    S_ESW   = 11'b00100000000,
    S_UPD   = 11'b01000000000,
    S_ADV   = 11'b10000000000
  } state_t;

  state_t state;
  logic [SPD_W-1:0]  speed_limit, accel_limit, lat_limit;
  logic [DT_W-1:0]   tick_period;
  logic [POS_W-1:0]  path_length;
  logic [POS_W-1:0]  position;
  logic [TIME_W-1:0] elapsed;
  logic [SPD_W-1:0]  current_speed;
  logic              finished;
  logic [K_W-1:0]    kraw;
  logic              kneg;
  logic [K_W:0]      absk;
  logic [63:0]       ad;
  logic [SPD_W-1:0]  vc;
  logic [POS_W-1:0]  ramp_dist;
  logic [51:0]       ramp_prod;
  logic              env_const;
  logic              pend_final;
  logic              ob_valid;
  logic [OUT_W-1:0]  ob_data;
  logic              ob_last;

  div_req_t dreq;
  div_rsp_t drsp;
  logic        sq_start;
  logic [63:0] sq_arg;
  logic        sq_done;
  logic [31:0] sq_root;

  clts_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  clts_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .arg(sq_arg),
                    .done(sq_done), .root(sq_root));

  logic idle_ok;
  assign idle_ok = (state == S_IDLE) && !ob_valid && !pend_final;
  assign s_axis_tready = idle_ok;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = ob_valid;
  assign m_axis_tdata = ob_data;
  assign m_axis_tlast = ob_last;

  // envelope decision, given accel distance ad
  logic [63:0] L64, P64, rest64;
  logic        tri_mode;
  assign L64 = {33'd0, path_length};
  assign P64 = {33'd0, position};
  assign rest64 = (P64 < L64) ? L64 - P64 : 64'd0;
  assign tri_mode = (accel_limit == '0) || ((ad << 1) > L64);
  assign ramp_prod = {31'd0, accel_limit, 1'b0} * {21'd0, ramp_dist};

  // rate limiter, result packing
  logic [SPD_W+1:0] maxdv;
  logic [63:0] dvprod;
  logic [31:0] vt;
  logic [31:0] desired;
  logic [22:0] cs_plus, des_plus;
  logic [22:0] vnew;
  logic [SPD_W-1:0] vclamp;
  assign dvprod = ({44'd0, accel_limit} * {47'd0, tick_period}) >> FRAC_BITS;
  assign maxdv = dvprod[SPD_W+1:0];
  assign vt = env_const ? {12'd0, speed_limit} : sq_root;
  assign desired = (vt < {12'd0, vc}) ? vt : {12'd0, vc};
  assign cs_plus = {3'd0, current_speed} + {1'b0, maxdv};
  assign des_plus = desired[22:0] + {1'b0, maxdv};
  always_comb begin
    if (desired > {9'd0, cs_plus}) vnew = cs_plus;
    else if ((desired[31:23] == '0) && (des_plus < {3'd0, current_speed}))
      vnew = {3'd0, current_speed} - {1'b0, maxdv};
    else vnew = desired[22:0];
    if (vnew > {3'd0, speed_limit}) vnew = {3'd0, speed_limit};
    if (vnew < {3'd0, MIN_SPEED}) vnew = {3'd0, MIN_SPEED};
    vclamp = vnew[SPD_W-1:0];
  end

  logic [63:0] trprod, trmag;
  logic [31:0] turn;
  logic [63:0] stepv;
  logic [63:0] posn;
  logic [32:0] tnext;
  assign trprod = ({44'd0, current_speed} * {31'd0, absk}) >> FRAC_BITS;
  always_comb begin
    trmag = trprod;
    if (kneg) begin
      if (trmag > 64'h8000_0000) trmag = 64'h8000_0000;
      turn = 32'(64'h1_0000_0000 - trmag);
    end else begin
      if (trmag > 64'h7FFF_FFFF) trmag = 64'h7FFF_FFFF;
      turn = trmag[31:0];
    end
  end
  assign stepv = ({44'd0, current_speed} * {47'd0, tick_period}) >> FRAC_BITS;
  assign posn = P64 + stepv;
  assign tnext = {1'b0, elapsed} + {16'd0, tick_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      speed_limit <= SPD_W'(32768);
      accel_limit <= SPD_W'(32768);
      lat_limit <= SPD_W'(65536);
      tick_period <= DT_W'(3277);
      path_length <= POS_W'(65536);
      position <= '0;
      elapsed <= '0;
      current_speed <= '0;
      finished <= 1'b0;
      pend_final <= 1'b0;
      ob_valid <= 1'b0;
      dreq.start <= 1'b0;
      sq_start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      sq_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SPEED_LIMIT: speed_limit <= cfg_data[SPD_W-1:0];
          REG_ACCEL_LIMIT: accel_limit <= cfg_data[SPD_W-1:0];
          REG_LAT_LIMIT:   lat_limit <= cfg_data[SPD_W-1:0];
          REG_TICK_PERIOD: tick_period <= cfg_data[DT_W-1:0];
          REG_PATH_LENGTH: path_length <= cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
      if (ob_valid && m_axis_tready) ob_valid <= 1'b0;
      if (pend_final && (!ob_valid || m_axis_tready)) begin
        ob_valid <= 1'b1;
        ob_last <= 1'b1;
        ob_data <= {5'd0, elapsed, path_length, 32'd0, 32'd0, 20'd0};
        pend_final <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kraw <= s_axis_tdata;
            kneg <= s_axis_tdata[31];
            absk <= s_axis_tdata[31] ? 33'h1_0000_0000 - {1'b0, s_axis_tdata}
                                      : {1'b0, s_axis_tdata};
            if (s_axis_tuser) begin
              position <= '0;
              elapsed <= '0;
              current_speed <= '0;
              finished <= 1'b0;
              state <= S_AD;
            end else if (!finished) begin
              state <= S_AD;
            end
          end
        end
        S_AD: begin
          if (position >= path_length) begin
            pend_final <= 1'b1;
            finished <= 1'b1;
            state <= S_IDLE;
          end else if (accel_limit == '0) begin
            ad <= '0;
            state <= S_CK;
          end else begin
            dreq.start <= 1'b1;
            dreq.num <= {24'd0, speed_limit} * {24'd0, speed_limit};
            dreq.den <= {43'd0, accel_limit, 1'b0};
            state <= S_ADW;
          end
        end
        S_ADW: if (drsp.done) begin
          ad <= drsp.quo;
          state <= S_CK;
        end
        S_CK: begin
          if (absk < {1'b0, STRAIGHT}) begin
            vc <= speed_limit;
            state <= S_ES;
          end else begin
            dreq.start <= 1'b1;
            dreq.num <= {44'd0, lat_limit} << FRAC_BITS;
            dreq.den <= {31'd0, absk};
            state <= S_CKW;
          end
        end
        S_CKW: if (drsp.done) begin
          sq_start <= 1'b1;
          sq_arg <= ((drsp.quo > QCAP) ? QCAP : drsp.quo) << FRAC_BITS;
          state <= S_CSW;
        end
        S_CSW: if (sq_done) begin
          vc <= (sq_root < {12'd0, speed_limit}) ? sq_root[SPD_W-1:0] : speed_limit;
          state <= S_ES;
        end
        S_ES: begin
          env_const <= 1'b0;
          if (tri_mode) ramp_dist <= (P64 < (L64 >> 1)) ? position : rest64[POS_W-1:0];
          else if (P64 < ad) ramp_dist <= position;
          else if (P64 < L64 - ad) env_const <= 1'b1;
          else ramp_dist <= rest64[POS_W-1:0];
          state <= S_CS;
        end
        S_CS: begin
          if (env_const) state <= S_UPD;
          else begin
            sq_start <= 1'b1;
            sq_arg <= {12'd0, ramp_prod};
            state <= S_ESW;
          end
        end
        S_ESW: if (sq_done) state <= S_UPD;
        S_UPD: begin
          current_speed <= vclamp;
          state <= S_ADV;
        end
        S_ADV: begin
          if (!ob_valid || m_axis_tready) begin
            ob_valid <= 1'b1;
            ob_last <= 1'b0;
            ob_data <= {5'd0, elapsed, position, kraw, turn, current_speed};
            position <= (posn > 64'h7FFF_FFFF) ? POS_W'(32'h7FFF_FFFF) : posn[POS_W-1:0];
            elapsed <= tnext[32] ? '1 : tnext[31:0];
            if (posn >= L64) begin
              pend_final <= 1'b1;
              finished <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_ready_idle;
    @(posedge clk) disable iff (rst) s_axis_tready |-> state == S_IDLE;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready while busy");
  property p_speed_floor;
    @(posedge clk) disable iff (rst) m_axis_tvalid && !m_axis_tlast |->
      m_axis_tdata[SPD_W-1:0] >= MIN_SPEED;
  endproperty
  a_speed_floor: assert property (p_speed_floor) else $error("speed below floor");
  property p_final_zero;
    @(posedge clk) disable iff (rst) m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[SPD_W-1:0] == '0;
  endproperty
  a_final_zero: assert property (p_final_zero) else $error("final speed nonzero");
  property p_fin;
    @(posedge clk) disable iff (rst) pend_final |-> finished;
  endproperty
  a_fin: assert property (p_fin) else $error("final pending without finish");
endmodule
